// File: rtl/gfpq_pkg.sv
// shared types, codes and defaults for the geodesic front priority queue
`default_nettype none
package gfpq_pkg;

  // default sizes
  localparam int VERTEX_COUNT_DEF = 1024;
  localparam int QUEUE_DEPTH_DEF  = 256;

  // field widths
  localparam int OP_W     = 3;
  localparam int EDGE_W   = 16;
  localparam int VIDX_W   = 10;
  localparam int FACE_W   = 16;
  localparam int DIST_W   = 32;
  localparam int STAT_W   = 3;
  localparam int QCNT_W   = 9;
  localparam int IN_W     = 88;
  localparam int OUT_W    = 144;

  // opcodes
  localparam logic [OP_W-1:0] OP_ADD_VERTEX = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_EDGE   = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd2;
  localparam logic [OP_W-1:0] OP_POP        = 3'd3;
  localparam logic [OP_W-1:0] OP_HAS        = 3'd4;
  localparam logic [OP_W-1:0] OP_MAX_DIST   = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_UNKNOWN   = 3'd4;

  // one queued front edge
  typedef struct packed {
    logic [EDGE_W-1:0] edge_id;
    logic [FACE_W-1:0] face_id;
    logic [VIDX_W-1:0] vertex_a;
    logic [VIDX_W-1:0] vertex_b;
  } qent_t;

  // one vertex table word
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] vdist;
  } vent_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SCAN,
    S_DECIDE,
    S_BUILD,
    S_MAX,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/gfpq_cell.sv
// one queue cell: holds an entry and takes its neighbor's entry on shift
`default_nettype none
module gfpq_cell (
  input  wire logic           clk,
  input  wire logic           shift,
  input  wire gfpq_pkg::qent_t d,
  output gfpq_pkg::qent_t     q
);
  import gfpq_pkg::*;

  qent_t ent_r;

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (shift) begin
      ent_r <= d;
    end
  end

  assign q = ent_r;

endmodule
`default_nettype wire

// File: rtl/gfpq_vtab.sv
// vertex table: valid flag and distance, one write and two registered reads
`default_nettype none
module gfpq_vtab #(
  parameter int VERTEX_COUNT = gfpq_pkg::VERTEX_COUNT_DEF,
  parameter int VAW          = $clog2(VERTEX_COUNT)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [VAW-1:0]   waddr,
  input  wire gfpq_pkg::vent_t  wdata,
  input  wire logic [VAW-1:0]   ra_addr,
  input  wire logic [VAW-1:0]   rb_addr,
  output gfpq_pkg::vent_t       ra_data,
  output gfpq_pkg::vent_t       rb_data
);
  import gfpq_pkg::*;

  vent_t mem [VERTEX_COUNT];
  vent_t ra_r;
  vent_t rb_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two read ports with registered data
  always_ff @(posedge clk) begin
    ra_r <= mem[ra_addr];
    rb_r <= mem[rb_addr];
  end

  assign ra_data = ra_r;
  assign rb_data = rb_r;

endmodule
`default_nettype wire

// File: rtl/geodesic_front_priority_queue.sv
// Geodesic front priority queue: a vertex distance table and a sorted queue of front edges
// The queue is a ring of QUEUE_DEPTH cells that rotates one place per cycle while it is
// scanned or rebuilt, so each queue operation that is carried out walks the whole ring:
// has_edge makes one pass, add_edge and a remove_edge that finds its edge make two (one
// pass to find the place, one pass to rebuild), pop_front makes one rebuild pass.
// add_vertex and the unused opcodes walk no ring; max_distance makes a single sweep over
// the vertex table memory. After reset the block clears the vertex table, one entry per
// cycle, and takes its first item only once every entry is cleared. A finished result
// waits in an output register while the next item is taken.
`default_nettype none
module geodesic_front_priority_queue #(
  parameter int VERTEX_COUNT = gfpq_pkg::VERTEX_COUNT_DEF,
  parameter int QUEUE_DEPTH  = gfpq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // opcode, edge_id, vertex_a, vertex_b, face_id, distance, zero pad
  input  wire logic [gfpq_pkg::IN_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // status, out_edge, out_face, dist_a, dist_b, max_dist, found, queue_count, zero pad
  output logic [gfpq_pkg::OUT_W-1:0]      out_tdata
);
  import gfpq_pkg::*;

  localparam int VAW = $clog2(VERTEX_COUNT);
  localparam int LW  = $clog2(QUEUE_DEPTH + 1);

  // input fields
  logic [OP_W-1:0]   in_op;
  logic [EDGE_W-1:0] in_edge;
  logic [VIDX_W-1:0] in_va;
  logic [VIDX_W-1:0] in_vb;
  logic [FACE_W-1:0] in_face;
  logic [DIST_W-1:0] in_dist;

  assign in_op   = in_tdata[2:0];
  assign in_edge = in_tdata[18:3];
  assign in_va   = in_tdata[28:19];
  assign in_vb   = in_tdata[38:29];
  assign in_face = in_tdata[54:39];
  assign in_dist = in_tdata[86:55];

  state_t state_r, state_nxt;

  logic [OP_W-1:0]   op_r;
  logic [EDGE_W-1:0] edge_r;
  logic [VIDX_W-1:0] va_r;
  logic [VIDX_W-1:0] vb_r;
  logic [FACE_W-1:0] face_r;
  logic [DIST_W-1:0] dist_r;

  logic [LW-1:0]     len_r;
  logic [LW-1:0]     k_r;
  logic [LW-1:0]     pos_r;
  logic              hit_r;
  logic [DIST_W-1:0] lo_r, hi_r;
  logic              pv_r;
  logic [LW-1:0]     pk_r;
  logic              pmatch_r;
  logic [VAW:0]      mcnt_r;
  logic [DIST_W-1:0] md_r;
  qent_t             buf_r;

  logic [STAT_W-1:0] status_r;
  logic              found_r;
  logic [EDGE_W-1:0] oe_r;
  logic [FACE_W-1:0] of_r;
  logic [DIST_W-1:0] da_r, db_r;

  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  // queue ring
  qent_t cell_q [QUEUE_DEPTH];
  qent_t ring_in;
  logic  ring_shift;

  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    qent_t d;
    if (gi == QUEUE_DEPTH - 1) begin : g_tail
      assign d = ring_in;
    end else begin : g_mid
      assign d = cell_q[gi+1];
    end
    gfpq_cell u_cell (
      .clk   (clk),
      .shift (ring_shift),
      .d     (d),
      .q     (cell_q[gi])
    );
  end

  // vertex table
  logic           vt_we;
  logic [VAW-1:0] vt_waddr;
  vent_t          vt_wdata;
  logic [VAW-1:0] vt_ra, vt_rb;
  vent_t          vt_da, vt_db;

  gfpq_vtab #(
    .VERTEX_COUNT (VERTEX_COUNT),
    .VAW          (VAW)
  ) u_vtab (
    .clk     (clk),
    .we      (vt_we),
    .waddr   (vt_waddr),
    .wdata   (vt_wdata),
    .ra_addr (vt_ra),
    .rb_addr (vt_rb),
    .ra_data (vt_da),
    .rb_data (vt_db)
  );

  // vertex index range checks and address conversion
  logic [31:0] va_ext, vb_ext, ha_ext, hb_ext;
  logic        va_in, vb_in;
  logic        accept;
  logic        k_end, k_last, m_end, clr_last;
  logic [DIST_W-1:0] el, eh;
  logic        new_better;

  assign va_ext   = 32'(va_r);
  assign vb_ext   = 32'(vb_r);
  assign ha_ext   = 32'(cell_q[0].vertex_a);
  assign hb_ext   = 32'(cell_q[0].vertex_b);
  assign va_in    = va_ext < 32'(VERTEX_COUNT);
  assign vb_in    = vb_ext < 32'(VERTEX_COUNT);
  assign accept   = in_tvalid && in_tready;
  assign k_end    = k_r == LW'(QUEUE_DEPTH);
  assign k_last   = k_r == LW'(QUEUE_DEPTH - 1);
  assign m_end    = mcnt_r == (VAW+1)'(VERTEX_COUNT);
  assign clr_last = mcnt_r == (VAW+1)'(VERTEX_COUNT - 1);
  assign el       = (vt_da.vdist < vt_db.vdist) ? vt_da.vdist : vt_db.vdist;
  assign eh       = (vt_da.vdist < vt_db.vdist) ? vt_db.vdist : vt_da.vdist;
  assign new_better = !vt_da.valid || (vt_da.vdist > dist_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_last) state_nxt = S_IDLE;
      S_IDLE:   if (accept) state_nxt = S_READ;
      S_READ:   state_nxt = S_EVAL;
      S_EVAL: begin
        unique case (op_r)
          OP_ADD_EDGE: begin
            if (va_in && vb_in && vt_da.valid && vt_db.valid &&
                len_r != LW'(QUEUE_DEPTH)) begin
              state_nxt = S_SCAN;
            end else begin
              state_nxt = S_DONE;
            end
          end
          OP_REMOVE, OP_HAS: state_nxt = S_SCAN;
          OP_POP:      state_nxt = (len_r == '0) ? S_DONE : S_BUILD;
          OP_MAX_DIST: state_nxt = S_MAX;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_SCAN:   if (k_end) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (op_r == OP_ADD_EDGE || (op_r == OP_REMOVE && hit_r)) begin
          state_nxt = S_BUILD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_BUILD:  if (k_last) state_nxt = S_DONE;
      S_MAX:    if (m_end) state_nxt = S_DONE;
      S_DONE:   if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer: memory ports, ring control and input ready
  always_comb begin
    vt_we      = 1'b0;
    vt_waddr   = va_ext[VAW-1:0];
    vt_wdata   = '{valid: 1'b1, vdist: dist_r};
    vt_ra      = va_ext[VAW-1:0];
    vt_rb      = vb_ext[VAW-1:0];
    ring_shift = 1'b0;
    ring_in    = cell_q[0];
    in_tready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        vt_we    = 1'b1;
        vt_waddr = mcnt_r[VAW-1:0];
        vt_wdata = '{valid: 1'b0, vdist: '0};
      end
      S_IDLE:  in_tready = 1'b1;
      S_READ: begin
        if (op_r == OP_POP) begin
          vt_ra = ha_ext[VAW-1:0];
          vt_rb = hb_ext[VAW-1:0];
        end
      end
      S_EVAL: begin
        vt_we = (op_r == OP_ADD_VERTEX) && va_in && new_better;
      end
      S_SCAN: begin
        vt_ra      = ha_ext[VAW-1:0];
        vt_rb      = hb_ext[VAW-1:0];
        ring_shift = !k_end;
      end
      S_BUILD: begin
        ring_shift = 1'b1;
        if (k_r < pos_r) begin
          ring_in = cell_q[0];
        end else if (op_r == OP_ADD_EDGE) begin
          if (k_r == pos_r) begin
            ring_in = '{edge_id: edge_r, face_id: face_r, vertex_a: va_r, vertex_b: vb_r};
          end else begin
            ring_in = buf_r;
          end
        end else begin
          ring_in = cell_q[1];
        end
      end
      S_MAX: begin
        vt_ra = mcnt_r[VAW-1:0];
      end
      S_DECIDE, S_DONE: ;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      len_r       <= '0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR || state_r == S_MAX) begin
        mcnt_r <= mcnt_r + 1'b1;
      end else if (state_r == S_EVAL) begin
        mcnt_r <= '0;
      end
      if (state_r == S_BUILD && k_last) begin
        len_r <= (op_r == OP_ADD_EDGE) ? len_r + 1'b1 : len_r - 1'b1;
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_r     <= in_op;
          edge_r   <= in_edge;
          va_r     <= in_va;
          vb_r     <= in_vb;
          face_r   <= in_face;
          dist_r   <= in_dist;
          status_r <= STAT_OK;
          found_r  <= 1'b0;
          oe_r     <= '0;
          of_r     <= '0;
          da_r     <= '0;
          db_r     <= '0;
          md_r     <= '0;
        end
      end
      S_EVAL: begin
        k_r   <= '0;
        hit_r <= 1'b0;
        pos_r <= len_r;
        pv_r  <= 1'b0;
        unique case (op_r)
          OP_ADD_VERTEX: if (!va_in) status_r <= STAT_UNKNOWN;
          OP_ADD_EDGE: begin
            lo_r <= el;
            hi_r <= eh;
            if (!(va_in && vb_in && vt_da.valid && vt_db.valid)) begin
              status_r <= STAT_UNKNOWN;
            end else if (len_r == LW'(QUEUE_DEPTH)) begin
              status_r <= STAT_FULL;
            end
          end
          OP_POP: begin
            pos_r <= '0;
            if (len_r == '0) begin
              status_r <= STAT_EMPTY;
            end else begin
              oe_r <= cell_q[0].edge_id;
              of_r <= cell_q[0].face_id;
              da_r <= vt_da.vdist;
              db_r <= vt_db.vdist;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        // issue the head entry, then judge it in the next cycle
        if (!k_end) begin
          k_r <= k_r + 1'b1;
        end
        pv_r     <= !k_end;
        pk_r     <= k_r;
        pmatch_r <= cell_q[0].edge_id == edge_r;
        if (pv_r && !hit_r && pk_r < len_r) begin
          if (op_r == OP_ADD_EDGE) begin
            if (el > lo_r) begin
              hit_r <= 1'b1;
              pos_r <= pk_r;
            end else if (el == lo_r) begin
              hit_r <= 1'b1;
              pos_r <= (eh > hi_r) ? pk_r : pk_r + 1'b1;
            end
          end else if (pmatch_r) begin
            hit_r <= 1'b1;
            pos_r <= pk_r;
          end
        end
      end
      S_DECIDE: begin
        k_r <= '0;
        if (op_r == OP_REMOVE || op_r == OP_HAS) begin
          if (hit_r) begin
            found_r <= 1'b1;
          end else begin
            status_r <= STAT_NOT_FOUND;
          end
        end
      end
      S_BUILD: begin
        k_r <= k_r + 1'b1;
        if (k_r >= pos_r) begin
          buf_r <= cell_q[0];
        end
      end
      S_MAX: begin
        // compare the word read in the previous cycle
        pv_r <= !m_end;
        if (pv_r && vt_da.valid && vt_da.vdist > md_r) begin
          md_r <= vt_da.vdist;
        end
      end
      S_CLEAR, S_READ, S_DONE: ;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= {3'b000, QCNT_W'(len_r), found_r, md_r, db_r, da_r, of_r, oe_r, status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// File: verif/gfpq_checker.sv
// item monitor, queue predictor and result comparator for the front priority queue
`default_nettype none
module gfpq_checker
  import gfpq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,
  input  wire logic             out_tvalid,
  input  wire logic             out_tready,
  input  wire logic [OUT_W-1:0] out_tdata,
  output int                    fail_count,
  output int                    pending,
  output int                    result_count
);

  // one predicted result
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [EDGE_W-1:0] out_edge;
    logic [FACE_W-1:0] out_face;
    logic [DIST_W-1:0] dist_a;
    logic [DIST_W-1:0] dist_b;
    logic [DIST_W-1:0] max_dist;
    logic              found;
    logic [QCNT_W-1:0] queue_count;
  } front_result_t;

  localparam int NVERT = VERTEX_COUNT_DEF;
  localparam int QDEPTH = QUEUE_DEPTH_DEF;

  // shadow of the vertex table and the edge queue
  bit                vert_known[NVERT];
  logic [DIST_W-1:0] vert_dist[NVERT];
  qent_t             front_q[$];
  front_result_t     expected_q[$];

  function automatic int find_front_edge(logic [EDGE_W-1:0] e);
    foreach (front_q[i])
      if (front_q[i].edge_id == e) return i;
    return -1;
  endfunction

  // work out the result of one item and update the shadow state
  function automatic front_result_t predict_front(logic [IN_W-1:0] item);
    front_result_t r;
    logic [OP_W-1:0]   op;
    logic [EDGE_W-1:0] e;
    logic [VIDX_W-1:0] va, vb;
    logic [FACE_W-1:0] f;
    logic [DIST_W-1:0] d, lo, hi, el, eh, da, db;
    qent_t ent;
    int pos, idx;
    op = item[2:0];
    e  = item[18:3];
    va = item[28:19];
    vb = item[38:29];
    f  = item[54:39];
    d  = item[86:55];
    r = '0;
    r.status = STAT_OK;
    case (op)
      OP_ADD_VERTEX: begin
        if (!vert_known[va]) begin
          vert_known[va] = 1'b1;
          vert_dist[va] = d;
        end else if (vert_dist[va] > d) begin
          vert_dist[va] = d;
        end
      end
      OP_ADD_EDGE: begin
        if (!vert_known[va] || !vert_known[vb]) begin
          r.status = STAT_UNKNOWN;
        end else if (front_q.size() >= QDEPTH) begin
          r.status = STAT_FULL;
        end else begin
          da = vert_dist[va];
          db = vert_dist[vb];
          lo = (da < db) ? da : db;
          hi = (da < db) ? db : da;
          pos = front_q.size();
          for (int i = 0; i < front_q.size(); i++) begin
            da = vert_dist[front_q[i].vertex_a];
            db = vert_dist[front_q[i].vertex_b];
            el = (da < db) ? da : db;
            eh = (da < db) ? db : da;
            if (el > lo) begin
              pos = i;
              break;
            end
            if (el == lo) begin
              pos = (eh > hi) ? i : i + 1;
              break;
            end
          end
          ent.edge_id = e;
          ent.face_id = f;
          ent.vertex_a = va;
          ent.vertex_b = vb;
          front_q.insert(pos, ent);
        end
      end
      OP_REMOVE: begin
        idx = find_front_edge(e);
        if (idx >= 0) begin
          front_q.delete(idx);
          r.found = 1'b1;
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
      OP_POP: begin
        if (front_q.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          ent = front_q.pop_front();
          r.out_edge = ent.edge_id;
          r.out_face = ent.face_id;
          r.dist_a = vert_dist[ent.vertex_a];
          r.dist_b = vert_dist[ent.vertex_b];
        end
      end
      OP_HAS: begin
        if (find_front_edge(e) >= 0) r.found = 1'b1;
        else r.status = STAT_NOT_FOUND;
      end
      OP_MAX_DIST: begin
        foreach (vert_known[i])
          if (vert_known[i] && vert_dist[i] > r.max_dist) r.max_dist = vert_dist[i];
      end
      default: ;
    endcase
    r.queue_count = QCNT_W'(front_q.size());
    return r;
  endfunction

  function automatic int field_ok(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch in %s: expected %h, got %h", $time, name, exp_v, act_v);
      return 0;
    end
    return 1;
  endfunction

  assign pending = expected_q.size();

  // watch both channels and compare each result item with the oldest prediction
  always @(posedge clk) begin
    front_result_t exp_r, act_r;
    int ok;
    if (!rst_n) begin
      foreach (vert_known[i]) vert_known[i] = 1'b0;
      front_q.delete();
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_q = {expected_q, predict_front(in_tdata)};
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        act_r.status      = out_tdata[2:0];
        act_r.out_edge    = out_tdata[18:3];
        act_r.out_face    = out_tdata[34:19];
        act_r.dist_a      = out_tdata[66:35];
        act_r.dist_b      = out_tdata[98:67];
        act_r.max_dist    = out_tdata[130:99];
        act_r.found       = out_tdata[131];
        act_r.queue_count = out_tdata[140:132];
        if (expected_q.size() == 0) begin
          $display("%0t: result item with none expected: %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          ok = field_ok("status", exp_r.status, act_r.status)
             & field_ok("out_edge", exp_r.out_edge, act_r.out_edge)
             & field_ok("out_face", exp_r.out_face, act_r.out_face)
             & field_ok("dist_a", exp_r.dist_a, act_r.dist_a)
             & field_ok("dist_b", exp_r.dist_b, act_r.dist_b)
             & field_ok("max_dist", exp_r.max_dist, act_r.max_dist)
             & field_ok("found", exp_r.found, act_r.found)
             & field_ok("queue_count", exp_r.queue_count, act_r.queue_count);
          if (!ok) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// stimulus, clock, reset and verdict for the front priority queue
`default_nettype none
module tb_top;
  import gfpq_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1830;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  int               fail_count, pending, result_count;
  int               tx_idle = 32;
  int               rx_idle = 87;
  int               items_sent = 0;
  int               quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  geodesic_front_priority_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  gfpq_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  // receiver backpressure
  always @(posedge clk) out_tready <= ($urandom_range(99) >= rx_idle);

  // watchdog on cycles without any accepted input or result item
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // offer one item, with a random gap before it, until accepted
  task automatic send_item(logic [OP_W-1:0] op, logic [EDGE_W-1:0] e, logic [VIDX_W-1:0] va,
                           logic [VIDX_W-1:0] vb, logic [FACE_W-1:0] f,
                           logic [DIST_W-1:0] d);
    bit taken;
    if ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, d, f, vb, va, e, op};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    items_sent++;
    // idling phases follow progress through the run
    if (items_sent == 620) begin
      tx_idle = 87;
      rx_idle = 32;
    end else if (items_sent == 1240) begin
      tx_idle = 0;
      rx_idle = 0;
    end
  endtask

  // vertex from a small pool at both ends of the table
  function automatic logic [VIDX_W-1:0] pool_vertex();
    logic [VIDX_W-1:0] v;
    v = VIDX_W'($urandom_range(15));
    if ($urandom_range(1)) v = 10'd1023 - v;
    return v;
  endfunction

  // distances biased toward ties
  function automatic logic [DIST_W-1:0] pick_dist();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return {16'($urandom_range(3)), 16'h0};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [EDGE_W-1:0] pick_edge();
    return $urandom_range(1) ? EDGE_W'($urandom_range(7)) : EDGE_W'($urandom_range(65535));
  endfunction

  task automatic random_item();
    int w;
    logic [VIDX_W-1:0] va, vb, rv;
    logic [EDGE_W-1:0] re;
    logic [FACE_W-1:0] rf;
    logic [DIST_W-1:0] rd;
    w = $urandom_range(99);
    va = pool_vertex();
    vb = pool_vertex();
    rv = VIDX_W'($urandom);
    re = EDGE_W'($urandom);
    rf = FACE_W'($urandom);
    rd = $urandom;
    if ($urandom_range(19) == 0) va = VIDX_W'($urandom_range(1023));
    if ($urandom_range(19) == 0) vb = VIDX_W'($urandom_range(1023));
    if (w < 20) send_item(OP_ADD_VERTEX, re, va, rv, rf, pick_dist());
    else if (w < 50) send_item(OP_ADD_EDGE, pick_edge(), va, vb, rf, rd);
    else if (w < 62) send_item(OP_REMOVE, pick_edge(), rv, vb, rf, rd);
    else if (w < 80) send_item(OP_POP, re, rv, vb, rf, rd);
    else if (w < 90) send_item(OP_HAS, pick_edge(), rv, vb, rf, rd);
    else if (w < 94) send_item(OP_MAX_DIST, re, rv, vb, rf, rd);
    else send_item($urandom_range(1) ? 3'd6 : 3'd7, re, rv, vb, rf, rd);
  endtask

  // fill the queue past its depth, then drain it past empty
  task automatic fill_and_drain();
    for (int i = 0; i < QUEUE_DEPTH_DEF + 6; i++)
      send_item(OP_ADD_EDGE, pick_edge(), pool_vertex(), pool_vertex(), FACE_W'($urandom), 0);
    for (int i = 0; i < QUEUE_DEPTH_DEF + 6; i++)
      send_item(OP_POP, 0, 0, 0, 0, 0);
  endtask

  initial begin
    int rand_count;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: table updates, empty queue, ties, duplicates, unused opcodes
    send_item(OP_ADD_VERTEX, 0, 10'd0, 0, 0, 32'h0005_0000);
    send_item(OP_ADD_VERTEX, 0, 10'd1023, 0, 0, 32'hFFFF_FFFF);
    send_item(OP_ADD_VERTEX, 0, 10'd1023, 0, 0, 32'h0002_0000);
    send_item(OP_ADD_VERTEX, 0, 10'd0, 0, 0, 32'h0009_0000);
    send_item(OP_POP, 0, 0, 0, 0, 0);
    send_item(OP_REMOVE, 16'h1234, 0, 0, 0, 0);
    send_item(OP_HAS, 16'h1234, 0, 0, 0, 0);
    send_item(OP_MAX_DIST, 0, 0, 0, 0, 0);
    send_item(OP_ADD_EDGE, 16'h0003, 10'd5, 10'd0, 0, 0);
    send_item(OP_ADD_EDGE, 16'hFFFF, 10'd0, 10'd1023, 16'hFFFF, 0);
    send_item(OP_ADD_EDGE, 16'h0001, 10'd1023, 10'd0, 16'h0001, 0);
    send_item(OP_ADD_VERTEX, 0, 10'd1, 0, 0, 32'h0002_0000);
    send_item(OP_ADD_EDGE, 16'h0002, 10'd1, 10'd1, 16'h0002, 0);
    send_item(OP_HAS, 16'h0001, 0, 0, 0, 0);
    send_item(OP_REMOVE, 16'hFFFF, 0, 0, 0, 0);
    send_item(OP_ADD_EDGE, 16'h0001, 10'd1, 10'd0, 16'h00AA, 0);
    send_item(OP_HAS, 16'h0001, 0, 0, 0, 0);
    send_item(OP_REMOVE, 16'h0001, 0, 0, 0, 0);
    send_item(3'd6, 16'hFFFF, 10'h3FF, 10'h3FF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(3'd7, 0, 0, 0, 0, 0);
    send_item(OP_POP, 0, 0, 0, 0, 0);
    send_item(OP_POP, 0, 0, 0, 0, 0);
    send_item(OP_POP, 0, 0, 0, 0, 0);
    send_item(OP_MAX_DIST, 0, 0, 0, 0, 0);

    // make the vertex pool known, then mixed traffic with two full sweeps
    for (int v = 0; v < 16; v++) begin
      send_item(OP_ADD_VERTEX, 0, VIDX_W'(v), 0, 0, pick_dist());
      send_item(OP_ADD_VERTEX, 0, VIDX_W'(1023 - v), 0, 0, pick_dist());
    end
    rand_count = 32;
    while (rand_count < RANDOM_ITEMS) begin
      if (rand_count == 300 || rand_count == 1300) begin
        fill_and_drain();
        rand_count += 2 * (QUEUE_DEPTH_DEF + 6);
      end else begin
        random_item();
        rand_count++;
      end
    end
    in_tvalid <= 1'b0;

    // drain the outstanding results, then let the block settle
    while (pending != 0) @(posedge clk);
    repeat (1100) @(posedge clk);

    $display("covered %0d items and %0d results: table updates, sorted inserts, full and",
             items_sent, result_count);
    $display("empty queue, duplicates and unused opcodes under three backpressure mixes");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
rtl/gfpq_pkg.sv
rtl/gfpq_cell.sv
rtl/gfpq_vtab.sv
rtl/geodesic_front_priority_queue.sv
verif/gfpq_checker.sv
verif/tb_top.sv
